/* rtl/core/atcp_pkg.sv */
// Shared constants, codes and types of the ASCII tone command frame parser.
package atcp_pkg;

   localparam int MAX_FRAME  = 100;
   localparam int SLOT_COUNT = 4;

   localparam int FLEN_W  = $clog2(MAX_FRAME + 1);
   localparam int SLOTS_W = $clog2(SLOT_COUNT + 1);
   localparam int SIDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_P_LO  = 8'h70;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   localparam logic [1:0] KIND_CHANNEL  = 2'd0;
   localparam logic [1:0] KIND_TIMING   = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      MD_SCAN,
      MD_BODY,
      MD_NUM,
      MD_FREQ,
      MD_PHASE,
      MD_SKIPM,
      MD_PERIOD,
      MD_DUTY
   } mode_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_READ,
      CS_LOAD,
      CS_TIME,
      CS_ERR
   } ctl_state_type;

   typedef struct packed {
      logic clear;
      logic take;
   } acc_ctrl_type;

endpackage

/* rtl/core/atcp_dec_acc.sv */
// Saturating decimal accumulator that stops at the first non-digit.
module atcp_dec_acc
   import atcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  acc_ctrl_type ctrl,
   input  logic [7:0]   digit_byte,
   output logic [31:0]  acc_value
);

   logic [31:0] acc_ff, acc_in;
   logic        stop_ff, stop_in;
   logic        is_digit;
   logic [3:0]  digit;
   logic [35:0] sum;

   assign is_digit = (digit_byte >= CH_ZERO) && (digit_byte <= CH_NINE);
   assign digit    = 4'(digit_byte - CH_ZERO);
   // times ten as two shifts and an add
   assign sum = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + 36'(digit);

   always_comb begin
      acc_in  = acc_ff;
      stop_in = stop_ff;
      if (ctrl.clear) begin
         acc_in  = '0;
         stop_in = 1'b0;
      end else if (ctrl.take && !stop_ff) begin
         if (!is_digit) begin
            stop_in = 1'b1;
         end else if (sum[35:32] != 4'd0) begin
            acc_in = '1;
         end else begin
            acc_in = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         stop_ff <= stop_in;
      end
   end

   assign acc_value = acc_ff;

endmodule

/* rtl/core/ascii_tone_command_frame_parser.sv */
// Top level of the ASCII tone command frame parser.
//
// Bytes arrive on the req_ channel and are parsed as they come: 'P','C' opens or
// restarts a frame and 'F','F' closes it. Frequency groups fill up to SLOT_COUNT
// slots held in two small synchronous memories (frequency, and channel number
// with phase); the frequency is written when its phase begins, or at frame end
// if it has none, and channel number with phase as each group completes. A byte
// that causes no result leaves the parser ready for the next byte. At frame end
// the input is held off while the slots are drained: each channel result takes
// one memory read with registered data and one output load, then the timing
// result, marked last, follows; the drain also waits while rsp_ready is low. An
// overflow (MAX_FRAME bytes without an end pair, counted also outside a frame)
// gives one error result, marked last, and drops the frame. The result sits in
// an output register, so the next transfer can be prepared while the previous
// one waits.
module ascii_tone_command_frame_parser
   import atcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_slot,
   output logic [7:0]  rsp_channel_number,
   output logic [31:0] rsp_frequency,
   output logic [15:0] rsp_phase,
   output logic [31:0] rsp_period,
   output logic [31:0] rsp_duty,
   output logic        rsp_last
);

   // control state
   ctl_state_type        cs_ff, cs_in;
   mode_type             mode_ff, mode_in;
   logic [7:0]           prev_ff, prev_in;
   logic [FLEN_W-1:0]    flen_ff, flen_in;
   logic [SLOTS_W-1:0]   slots_ff, slots_in;
   logic [7:0]           numl_ff, numl_in;
   logic [31:0]          period_ff, period_in;
   logic [31:0]          duty_ff, duty_in;
   logic [SLOTS_W-1:0]   dcnt_ff, dcnt_in;
   logic [SIDX_W-1:0]    didx_ff, didx_in;

   // slot memories
   logic [31:0]          freq_mem [SLOT_COUNT];
   logic [23:0]          np_mem   [SLOT_COUNT];
   logic [31:0]          freq_rd_ff;
   logic [23:0]          np_rd_ff;
   logic                 freq_we, np_we;
   logic [SIDX_W-1:0]    widx;
   logic [15:0]          np_phase;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [1:0]           slot_ff, slot_in;
   logic [7:0]           chan_ff, chan_in;
   logic [31:0]          freq_ff, freq_in;
   logic [15:0]          phase_ff, phase_in;
   logic [31:0]          oper_ff, oper_in;
   logic [31:0]          oduty_ff, oduty_in;
   logic                 last_ff, last_in;

   acc_ctrl_type         acc_ctl;
   logic [31:0]          acc_value;
   logic [15:0]          acc_sat16;
   logic                 accept;
   logic                 out_free;
   logic                 slot_free;
   logic [7:0]           b;

   atcp_dec_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (acc_ctl),
      .digit_byte (req_rx_byte),
      .acc_value  (acc_value)
   );

   assign b         = req_rx_byte;
   assign req_ready = (cs_ff == CS_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_free = slots_ff < SLOTS_W'(SLOT_COUNT);
   assign widx      = slots_ff[SIDX_W-1:0];
   assign acc_sat16 = (acc_value[31:16] != 16'd0) ? 16'hFFFF : acc_value[15:0];

   always_comb begin
      cs_in        = cs_ff;
      mode_in      = mode_ff;
      prev_in      = prev_ff;
      flen_in      = flen_ff;
      slots_in     = slots_ff;
      numl_in      = numl_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      dcnt_in      = dcnt_ff;
      didx_in      = didx_ff;
      acc_ctl      = '0;
      freq_we      = 1'b0;
      np_we        = 1'b0;
      np_phase     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      slot_in      = slot_ff;
      chan_in      = chan_ff;
      freq_in      = freq_ff;
      phase_in     = phase_ff;
      oper_in      = oper_ff;
      oduty_in     = oduty_ff;
      last_in      = last_ff;

      case (cs_ff)
         CS_IDLE: begin
            if (accept) begin
               if (flen_ff < FLEN_W'(MAX_FRAME)) begin
                  flen_in = flen_ff + FLEN_W'(1);
               end
               if (prev_ff == CH_F && b == CH_F) begin
                  if (mode_ff != MD_SCAN) begin
                     // close any open group
                     case (mode_ff)
                        MD_FREQ: begin
                           freq_we  = slot_free;
                           np_we    = slot_free;
                           np_phase = '0;
                           if (slot_free) begin
                              slots_in = slots_ff + SLOTS_W'(1);
                           end
                        end
                        MD_PHASE: begin
                           np_we    = slot_free;
                           np_phase = acc_sat16;
                           if (slot_free) begin
                              slots_in = slots_ff + SLOTS_W'(1);
                           end
                        end
                        MD_SKIPM: begin
                           period_in = '0;
                           duty_in   = '0;
                        end
                        MD_PERIOD: begin
                           period_in = acc_value;
                           duty_in   = '0;
                        end
                        MD_DUTY: begin
                           duty_in = acc_value;
                        end
                        default: begin
                        end
                     endcase
                     dcnt_in = slots_in;
                     didx_in = '0;
                     cs_in   = (slots_in == '0) ? CS_TIME : CS_READ;
                  end
                  // drop the frame
                  mode_in    = MD_SCAN;
                  flen_in    = '0;
                  prev_in    = '0;
                  slots_in   = '0;
                  numl_in    = '0;
                  acc_ctl    = '0;
                  acc_ctl.clear = 1'b1;
               end else begin
                  if (prev_ff == CH_P && b == CH_C) begin
                     mode_in       = MD_BODY;
                     flen_in       = FLEN_W'(2);
                     slots_in      = '0;
                     numl_in       = '0;
                     acc_ctl.clear = 1'b1;
                  end else begin
                     case (mode_ff)
                        MD_BODY, MD_NUM: begin
                           if (mode_ff == MD_NUM) begin
                              numl_in = b - CH_ZERO;
                           end
                           if (b == CH_N) begin
                              mode_in = MD_NUM;
                           end else if (b == CH_F_LO) begin
                              acc_ctl.clear = 1'b1;
                              mode_in       = MD_FREQ;
                           end else if (b == CH_T) begin
                              mode_in = MD_SKIPM;
                           end else begin
                              mode_in = MD_BODY;
                           end
                        end
                        MD_FREQ: begin
                           if (b == CH_P_LO) begin
                              freq_we       = slot_free;
                              acc_ctl.clear = 1'b1;
                              mode_in       = MD_PHASE;
                           end else begin
                              acc_ctl.take = 1'b1;
                           end
                        end
                        MD_PHASE: begin
                           if (b == CH_N || b == CH_F || b == CH_T) begin
                              np_we    = slot_free;
                              np_phase = acc_sat16;
                              if (slot_free) begin
                                 slots_in = slots_ff + SLOTS_W'(1);
                              end
                              numl_in       = '0;
                              acc_ctl.clear = 1'b1;
                              if (b == CH_N) begin
                                 mode_in = MD_NUM;
                              end else if (b == CH_T) begin
                                 mode_in = MD_SKIPM;
                              end else begin
                                 mode_in = MD_BODY;
                              end
                           end else begin
                              acc_ctl.take = 1'b1;
                           end
                        end
                        MD_SKIPM: begin
                           acc_ctl.clear = 1'b1;
                           mode_in       = MD_PERIOD;
                        end
                        MD_PERIOD: begin
                           if (b == CH_T) begin
                              period_in     = acc_value;
                              acc_ctl.clear = 1'b1;
                              mode_in       = MD_DUTY;
                           end else begin
                              acc_ctl.take = 1'b1;
                           end
                        end
                        MD_DUTY: begin
                           if (b == CH_F) begin
                              duty_in       = acc_value;
                              acc_ctl.clear = 1'b1;
                              mode_in       = MD_BODY;
                           end else begin
                              acc_ctl.take = 1'b1;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  prev_in = b;
                  // overflow: drop the frame and report
                  if (flen_in >= FLEN_W'(MAX_FRAME)) begin
                     mode_in  = MD_SCAN;
                     flen_in  = '0;
                     prev_in  = '0;
                     slots_in = '0;
                     numl_in  = '0;
                     acc_ctl  = '0;
                     acc_ctl.clear = 1'b1;
                     cs_in    = CS_ERR;
                  end
               end
            end
         end
         CS_READ: begin
            // read data of slot didx_ff lands in the read registers
            cs_in = CS_LOAD;
         end
         CS_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_CHANNEL;
               slot_in      = 2'(didx_ff);
               chan_in      = np_rd_ff[23:16];
               freq_in      = freq_rd_ff;
               phase_in     = np_rd_ff[15:0];
               oper_in      = '0;
               oduty_in     = '0;
               last_in      = 1'b0;
               if (SLOTS_W'(didx_ff) + SLOTS_W'(1) == dcnt_ff) begin
                  cs_in = CS_TIME;
               end else begin
                  didx_in = didx_ff + SIDX_W'(1);
                  cs_in   = CS_READ;
               end
            end
         end
         CS_TIME: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_TIMING;
               slot_in      = '0;
               chan_in      = '0;
               freq_in      = '0;
               phase_in     = '0;
               oper_in      = period_ff;
               oduty_in     = duty_ff;
               last_in      = 1'b1;
               cs_in        = CS_IDLE;
            end
         end
         CS_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_OVERFLOW;
               slot_in      = '0;
               chan_in      = '0;
               freq_in      = '0;
               phase_in     = '0;
               oper_in      = '0;
               oduty_in     = '0;
               last_in      = 1'b1;
               cs_in        = CS_IDLE;
            end
         end
         default: begin
            cs_in = CS_IDLE;
         end
      endcase
   end

   // slot memories: write at the fill index, read at the drain index
   always_ff @(posedge clock) begin
      if (freq_we) begin
         freq_mem[widx] <= acc_value;
      end
      if (np_we) begin
         np_mem[widx] <= {numl_ff, np_phase};
      end
      freq_rd_ff <= freq_mem[didx_ff];
      np_rd_ff   <= np_mem[didx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff        <= CS_IDLE;
         mode_ff      <= MD_SCAN;
         prev_ff      <= '0;
         flen_ff      <= '0;
         slots_ff     <= '0;
         numl_ff      <= '0;
         period_ff    <= '0;
         duty_ff      <= '0;
         dcnt_ff      <= '0;
         didx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cs_ff        <= cs_in;
         mode_ff      <= mode_in;
         prev_ff      <= prev_in;
         flen_ff      <= flen_in;
         slots_ff     <= slots_in;
         numl_ff      <= numl_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         dcnt_ff      <= dcnt_in;
         didx_ff      <= didx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds while a transfer waits
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      slot_ff  <= slot_in;
      chan_ff  <= chan_in;
      freq_ff  <= freq_in;
      phase_ff <= phase_in;
      oper_ff  <= oper_in;
      oduty_ff <= oduty_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_channel_number = chan_ff;
   assign rsp_frequency      = freq_ff;
   assign rsp_phase          = phase_ff;
   assign rsp_period         = oper_ff;
   assign rsp_duty           = oduty_ff;
   assign rsp_last           = last_ff;

   a_slots_bounded: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= SLOTS_W'(SLOT_COUNT))
      else $error("slot fill count beyond slot count");

   a_flen_bounded: assert property (@(posedge clock) disable iff (reset)
      flen_ff < FLEN_W'(MAX_FRAME))
      else $error("frame length held at overflow limit");

   a_drain_index: assert property (@(posedge clock) disable iff (reset)
      (cs_ff == CS_READ || cs_ff == CS_LOAD) |-> SLOTS_W'(didx_ff) < dcnt_ff)
      else $error("drain index beyond filled slots");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (kind_ff != KIND_CHANNEL)))
      else $error("last flag does not match result kind");

   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      ((cs_ff == CS_TIME || cs_ff == CS_ERR) && out_free) |=> (cs_ff == CS_IDLE && rsp_last))
      else $error("final result of a frame end not marked last");

endmodule
